FILE: rtl/empc_pkg.sv
// empc_pkg: payload structs, codes and round trip profile constants for the
// encoder position motor controller. no dependencies.
package empc_pkg;

   localparam int POS_OUT_W  = 32;
   localparam int DUTY_W     = 8;
   localparam int PHASE_W    = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int TRIP_PHASES = 8;

   // input function codes
   localparam logic [1:0] FUNC_EDGE  = 2'd0;
   localparam logic [1:0] FUNC_TICK  = 2'd1;
   localparam logic [1:0] FUNC_START = 2'd2;

   // mode codes
   localparam logic [1:0] MODE_AUTO   = 2'd0;
   localparam logic [1:0] MODE_MANUAL = 2'd1;
   localparam logic [1:0] MODE_TRIP   = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MANUAL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN    = 3'd4;

   localparam logic [DUTY_W-1:0] MAX_SPEED_RST = 8'd200;
   localparam logic [DUTY_W-1:0] MIN_SPEED_RST = 8'd20;
   localparam logic [DUTY_W-1:0] DUTY_FULL     = 8'd255;

   localparam logic [PHASE_W-1:0] PHASE_DONE = 4'd8;

   // phases 0..3 run forward while pos < limit, 4..7 reverse while pos > limit
   localparam int TRIP_LIMIT [TRIP_PHASES] = '{300, 9400, 9900, 10000, 9700, 600, 100, 0};
   localparam logic [DUTY_W-1:0] TRIP_DUTY [TRIP_PHASES] =
      '{8'd80, 8'd255, 8'd80, 8'd30, 8'd80, 8'd255, 8'd80, 8'd30};

   typedef struct packed {
      logic [1:0] func;
      logic       enc_b;
   } req_type;

   typedef struct packed {
      logic [DUTY_W-1:0]           fwd_duty;
      logic [DUTY_W-1:0]           rvs_duty;
      logic signed [POS_OUT_W-1:0] position;
      logic                        trip_active;
      logic [PHASE_W-1:0]          trip_phase;
   } rsp_type;

   typedef struct packed {
      logic               busy;
      logic [PHASE_W-1:0] phase;
   } trip_state_type;

   typedef struct packed {
      logic               busy;
      logic [PHASE_W-1:0] phase;
      logic               drive_en;
      logic [DUTY_W-1:0]  fwd;
      logic [DUTY_W-1:0]  rvs;
   } trip_next_type;

endpackage

FILE: rtl/empc_trip.sv
// empc_trip: round trip phase sequencer, skips every phase whose condition
// fails in one pass using parallel threshold compares. depends on empc_pkg.
module empc_trip #(
   parameter int POS_WIDTH = 32
) (
   input  logic signed [POS_WIDTH-1:0] pos,
   input  empc_pkg::trip_state_type    cur,
   output empc_pkg::trip_next_type     nxt
);
   import empc_pkg::*;

   logic [TRIP_PHASES-1:0] stay;
   logic [2:0]             sel;
   logic                   found;

   always_comb begin
      for (int i = 0; i < TRIP_PHASES; i++) begin
         if (i < TRIP_PHASES / 2) begin
            stay[i] = pos < $signed(POS_WIDTH'(TRIP_LIMIT[i]));
         end else begin
            stay[i] = $signed(POS_WIDTH'(TRIP_LIMIT[i])) < pos;
         end
      end
   end

   // first phase at or after the current one that holds
   always_comb begin
      sel   = '0;
      found = 1'b0;
      for (int i = TRIP_PHASES - 1; i >= 0; i--) begin
         if (PHASE_W'(i) >= cur.phase && stay[i]) begin
            sel   = 3'(i);
            found = 1'b1;
         end
      end
   end

   always_comb begin
      nxt.busy     = cur.busy;
      nxt.phase    = cur.phase;
      nxt.drive_en = 1'b0;
      nxt.fwd      = '0;
      nxt.rvs      = '0;
      if (cur.busy) begin
         nxt.drive_en = 1'b1;
         if (found) begin
            nxt.phase = {1'b0, sel};
            if (!sel[2]) begin
               nxt.fwd = TRIP_DUTY[sel];
            end else begin
               nxt.rvs = TRIP_DUTY[sel];
            end
         end else begin
            // passed the last phase: stop the motor
            nxt.phase = PHASE_DONE;
            nxt.busy  = 1'b0;
         end
      end
   end

endmodule

FILE: rtl/encoder_position_motor_controller.sv
// encoder_position_motor_controller: top level with registers, next state
// logic and a two-entry result queue. depends on empc_pkg and empc_trip.
//
// usage
//   req channel: one transfer per event, func = encoder A rising edge,
//   control tick or round trip start; enc_b is channel B at the edge
//   rsp channel: exactly one result per req transfer, in order, carrying
//   both duties, the position after the event and round trip status
//   csr channel: register writes by index (mode, target, manual drive,
//   max speed, min speed); always ready, write only while the block is idle
//   throughput: one item per cycle while req_ready is high; each result is
//   registered into the queue on its req transfer, and the whole state update
//   (position step, error and clamp, eight parallel threshold compares) is combinational
//   stall: results sit in a two-entry queue, so req_ready stays high while
//   one result waits; it drops only when both entries are full
//   reset: synchronous, clears position, duties, trip state and the queue,
//   and loads max speed 200 and min speed 20
module encoder_position_motor_controller #(
   parameter int POS_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  empc_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output empc_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [empc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [empc_pkg::CSR_DATA_W-1:0]     csr_data
);
   import empc_pkg::*;

   // error needs one bit more than the wider of position and target
   localparam int ERR_W = ((POS_WIDTH > POS_OUT_W) ? POS_WIDTH : POS_OUT_W) + 1;

   // configuration registers
   logic [1:0]                  mode_ff;
   logic signed [POS_OUT_W-1:0] target_ff;
   logic signed [8:0]           manual_ff;
   logic [DUTY_W-1:0]           max_ff;
   logic [DUTY_W-1:0]           min_ff;

   // controller state
   logic signed [POS_WIDTH-1:0] pos_ff, pos_in;
   logic [DUTY_W-1:0]           fwd_ff, fwd_in;
   logic [DUTY_W-1:0]           rvs_ff, rvs_in;
   trip_state_type              trip_ff, trip_in;

   // result queue, slot 0 is the head
   rsp_type slot0_ff, slot1_ff;
   logic    v0_ff, v1_ff;

   logic req_xfer, rsp_xfer;
   rsp_type rsp_new;

   assign csr_ready = 1'b1;
   assign req_ready = ~v1_ff;
   assign req_xfer  = req_valid & req_ready;
   assign rsp_valid = v0_ff;
   assign rsp_data  = slot0_ff;
   assign rsp_xfer  = v0_ff & rsp_ready;

   // register writes, unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_AUTO;
         target_ff <= '0;
         manual_ff <= '0;
         max_ff    <= MAX_SPEED_RST;
         min_ff    <= MIN_SPEED_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MODE:   mode_ff   <= csr_data[1:0];
            CSR_TARGET: target_ff <= $signed(csr_data[POS_OUT_W-1:0]);
            CSR_MANUAL: manual_ff <= $signed(csr_data[8:0]);
            CSR_MAX:    max_ff    <= csr_data[DUTY_W-1:0];
            CSR_MIN:    min_ff    <= csr_data[DUTY_W-1:0];
            default: ;
         endcase
      end
   end

   // automatic mode: exact error, clamp to max, raise small errors to min
   logic signed [ERR_W-1:0] err;
   logic [ERR_W-1:0]        err_mag;
   logic                    auto_fwd;
   logic [DUTY_W-1:0]       auto_duty;

   always_comb begin
      err      = ERR_W'(target_ff) - ERR_W'(pos_ff);
      auto_fwd = ~err[ERR_W-1];
      err_mag  = auto_fwd ? err : -err;
      if (err_mag > ERR_W'(max_ff)) begin
         auto_duty = max_ff;
      end else if (err_mag != '0 && err_mag < ERR_W'(min_ff)) begin
         auto_duty = min_ff;
      end else begin
         auto_duty = err_mag[DUTY_W-1:0];
      end
   end

   // manual mode: sign picks direction, -256 saturates to full duty
   logic       man_fwd;
   logic [8:0] man_mag;
   logic [DUTY_W-1:0] man_duty;

   always_comb begin
      man_fwd  = ~manual_ff[8];
      man_mag  = man_fwd ? manual_ff : -manual_ff;
      man_duty = man_mag[8] ? DUTY_FULL : man_mag[DUTY_W-1:0];
   end

   // next state for the item at the req port
   trip_state_type trip_mid;
   trip_next_type  trip_nxt;
   logic           start;

   always_comb begin
      pos_in = pos_ff;
      fwd_in = fwd_ff;
      rvs_in = rvs_ff;
      start  = 1'b0;
      case (req_data.func)
         FUNC_EDGE: begin
            pos_in = req_data.enc_b ? pos_ff + POS_WIDTH'(1) : pos_ff - POS_WIDTH'(1);
         end
         FUNC_TICK: begin
            // a running trip owns the motor
            if (!trip_ff.busy) begin
               if (mode_ff == MODE_AUTO) begin
                  fwd_in = auto_fwd ? auto_duty : '0;
                  rvs_in = auto_fwd ? '0 : auto_duty;
               end else if (mode_ff == MODE_MANUAL) begin
                  fwd_in = man_fwd ? man_duty : '0;
                  rvs_in = man_fwd ? '0 : man_duty;
               end
            end
         end
         FUNC_START: begin
            start = (mode_ff == MODE_TRIP);
         end
         default: ;
      endcase
      trip_mid.busy  = trip_ff.busy | start;
      trip_mid.phase = start ? '0 : trip_ff.phase;
   end

   empc_trip #(
      .POS_WIDTH(POS_WIDTH)
   ) u_trip (
      .pos(pos_in),
      .cur(trip_mid),
      .nxt(trip_nxt)
   );

   always_comb begin
      trip_in.busy  = trip_nxt.busy;
      trip_in.phase = trip_nxt.phase;
      rsp_new.fwd_duty    = trip_nxt.drive_en ? trip_nxt.fwd : fwd_in;
      rsp_new.rvs_duty    = trip_nxt.drive_en ? trip_nxt.rvs : rvs_in;
      rsp_new.position    = POS_OUT_W'(pos_in);
      rsp_new.trip_active = trip_nxt.busy;
      rsp_new.trip_phase  = trip_nxt.phase;
   end

   // state moves only on a req transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         fwd_ff  <= '0;
         rvs_ff  <= '0;
         trip_ff <= '0;
      end else if (req_xfer) begin
         pos_ff  <= pos_in;
         fwd_ff  <= rsp_new.fwd_duty;
         rvs_ff  <= rsp_new.rvs_duty;
         trip_ff <= trip_in;
      end
   end

   // result queue control; a push never meets a full queue
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else begin
         if (rsp_xfer) begin
            v0_ff <= v1_ff | req_xfer;
            v1_ff <= 1'b0;
         end else if (req_xfer) begin
            v0_ff <= 1'b1;
            v1_ff <= v0_ff;
         end
      end
   end

   // result queue payload
   always_ff @(posedge clock) begin
      if (rsp_xfer) begin
         slot0_ff <= v1_ff ? slot1_ff : rsp_new;
      end else if (req_xfer && !v0_ff) begin
         slot0_ff <= rsp_new;
      end
      if (req_xfer && v0_ff && !rsp_xfer) begin
         slot1_ff <= rsp_new;
      end
   end

endmodule

FILE: rtl/empc_checker.sv
// empc_checker: port level assertions for the motor controller and the bind
// that attaches them. depends on empc_pkg and the top level.
module empc_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input empc_pkg::rsp_type rsp_data
);
   import empc_pkg::*;

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // only one direction is ever driven
   a_one_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.fwd_duty == '0 || rsp_data.rvs_duty == '0))
      else $error("both duties nonzero");

   // an active trip sits in one of its eight phases, a finished one stops
   a_trip_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.trip_active ? (rsp_data.trip_phase < PHASE_DONE)
                                          : (rsp_data.trip_phase <= PHASE_DONE)))
      else $error("trip phase out of range");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind encoder_position_motor_controller empc_checker u_empc_checker (.*);
